// ===== hdl/plvr_pkg.sv =====
`timescale 1ns / 1ps

package plvr_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int REG_W    = 32;
    localparam int COLOR_W  = 16;
    localparam int CFG_IW   = 2;

    // discriminant and its root
    localparam int SQ_DW    = 68;
    localparam int SQ_RW    = 34;
    localparam int SQ_REMW  = SQ_RW + 2;

    // divide: numerator (root - linear) * gain, divisor twice the quadratic term
    localparam int DV_W     = REG_W + 1;
    localparam int NUM_W    = SQ_RW;
    localparam int PROD_W   = NUM_W + REG_W;
    localparam int DREM_W   = PROD_W - REG_W;

    // floor(x / 5) = (x * RECIP5) >> RECIP_SHIFT for x below 2^34
    localparam int         RECIP_W     = 34;
    localparam int         RECIP_SHIFT = 36;
    localparam logic [RECIP_W-1:0] RECIP5 = 34'd13743895348;

    localparam logic [REG_W-1:0] CONST_RST = 32'd65536;
    localparam logic [REG_W-1:0] LIN_RST   = 32'd45875;
    localparam logic [REG_W-1:0] QUAD_RST  = 32'd117965;
    localparam logic [REG_W-1:0] GAIN_RST  = 32'd65536;

    typedef enum logic [CFG_IW-1:0] {
        REG_CONST = 2'd0,
        REG_LIN   = 2'd1,
        REG_QUAD  = 2'd2,
        REG_GAIN  = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_QZERO   = 2'd1,
        ST_NEGDISC = 2'd2,
        ST_SAT     = 2'd3
    } status_t;

    // control that travels beside the data
    typedef struct packed {
        logic    valid;
        status_t status;
        logic    sat_max;
    } tag_t;

endpackage

// ===== hdl/plvr_sqrt.sv =====
`timescale 1ns / 1ps

module plvr_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  plvr_pkg::tag_t                in_tag,
    input  logic [plvr_pkg::SQ_DW-1:0]    in_d,
    output plvr_pkg::tag_t                out_tag,
    output logic [plvr_pkg::SQ_RW-1:0]    out_root
);

    localparam int DW   = plvr_pkg::SQ_DW;
    localparam int RW   = plvr_pkg::SQ_RW;
    localparam int REMW = plvr_pkg::SQ_REMW;

    plvr_pkg::tag_t     tag_reg  [0:RW-1];
    logic [DW-1:0]      d_reg    [0:RW-1];
    logic [REMW-1:0]    rem_reg  [0:RW-1];
    logic [RW-1:0]      root_reg [0:RW-1];

    // one root bit per stage
    for (genvar k = 0; k < RW; k++) begin : g_stage
        plvr_pkg::tag_t  prev_tag;
        logic [DW-1:0]   prev_d;
        logic [REMW-1:0] prev_rem;
        logic [RW-1:0]   prev_root;
        logic [REMW-1:0] rem_sh;
        logic [REMW-1:0] trial;
        logic            ge;

        if (k == 0) begin : g_first
            assign prev_tag  = in_tag;
            assign prev_d    = in_d;
            assign prev_rem  = '0;
            assign prev_root = '0;
        end
        else begin : g_next
            assign prev_tag  = tag_reg[k-1];
            assign prev_d    = d_reg[k-1];
            assign prev_rem  = rem_reg[k-1];
            assign prev_root = root_reg[k-1];
        end

        assign rem_sh = {prev_rem[REMW-3:0], prev_d[DW-1 -: 2]};
        assign trial  = {prev_root, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[k] <= '0;
            end
            else if (en)
            begin
                tag_reg[k] <= prev_tag;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k]    <= prev_d << 2;
                rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[k] <= {prev_root[RW-2:0], ge};
            end
        end
    end

    assign out_tag  = tag_reg[RW-1];
    assign out_root = root_reg[RW-1];

endmodule

// ===== hdl/plvr_div.sv =====
`timescale 1ns / 1ps

module plvr_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  plvr_pkg::tag_t                in_tag,
    input  logic [plvr_pkg::DREM_W-1:0]   in_rem,
    input  logic [plvr_pkg::REG_W-1:0]    in_lo,
    input  logic [plvr_pkg::DV_W-1:0]     dv,
    output plvr_pkg::tag_t                out_tag,
    output logic [plvr_pkg::REG_W-1:0]    out_q
);

    localparam int QW   = plvr_pkg::REG_W;
    localparam int REMW = plvr_pkg::DREM_W;

    plvr_pkg::tag_t   tag_reg [0:QW-1];
    logic [REMW-1:0]  rem_reg [0:QW-1];
    logic [QW-1:0]    lo_reg  [0:QW-1];

    // restoring division, quotient bits shift in as numerator bits shift out
    for (genvar k = 0; k < QW; k++) begin : g_stage
        plvr_pkg::tag_t  prev_tag;
        logic [REMW-1:0] prev_rem;
        logic [QW-1:0]   prev_lo;
        logic [REMW-1:0] rem_sh;
        logic [REMW-1:0] dv_ext;
        logic            ge;

        if (k == 0) begin : g_first
            assign prev_tag = in_tag;
            assign prev_rem = in_rem;
            assign prev_lo  = in_lo;
        end
        else begin : g_next
            assign prev_tag = tag_reg[k-1];
            assign prev_rem = rem_reg[k-1];
            assign prev_lo  = lo_reg[k-1];
        end

        assign rem_sh = {prev_rem[REMW-2:0], prev_lo[QW-1]};
        assign dv_ext = REMW'(dv);
        assign ge     = (rem_sh >= dv_ext);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[k] <= '0;
            end
            else if (en)
            begin
                tag_reg[k] <= prev_tag;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? (rem_sh - dv_ext) : rem_sh;
                lo_reg[k]  <= {prev_lo[QW-2:0], ge};
            end
        end
    end

    assign out_tag = tag_reg[QW-1];
    assign out_q   = lo_reg[QW-1];

endmodule

// ===== hdl/point_light_volume_radius_top.sv =====
// point light volume radius, fully pipelined
// pipeline: 4 front stages, 34 square-root stages, 3 middle stages,
//   32 divide stages and an output register
// throughput: one item per cycle; the whole pipe advances together and holds on stall
// reset: asynchronous active low; clears all valid bits and loads register defaults
`timescale 1ns / 1ps

module point_light_volume_radius_top #(
    parameter int FRAC_BITS = plvr_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input item
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [plvr_pkg::COLOR_W-1:0]    color_red,
    input  logic [plvr_pkg::COLOR_W-1:0]    color_green,
    input  logic [plvr_pkg::COLOR_W-1:0]    color_blue,
    // result item
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [plvr_pkg::REG_W-1:0]      light_radius,
    output logic [1:0]                      status,
    // configuration writes
    input  logic                            cfg_we,
    input  logic [plvr_pkg::CFG_IW-1:0]     cfg_index,
    input  logic [plvr_pkg::REG_W-1:0]      cfg_data
);

    localparam int CW    = plvr_pkg::COLOR_W;
    localparam int RGW   = plvr_pkg::REG_W;
    localparam int XW    = CW + FRAC_BITS - 7;          // brightest channel aligned for /5
    localparam int XPW   = XW + plvr_pkg::RECIP_W;
    localparam int TW    = XPW - plvr_pkg::RECIP_SHIFT; // 51.2*m in F fraction bits
    localparam int QTW   = RGW + TW + 2;
    localparam int NGW   = 2 * RGW + 2;
    localparam int DW    = plvr_pkg::SQ_DW;
    localparam int SRW   = plvr_pkg::SQ_RW;
    localparam int PW    = plvr_pkg::PROD_W;
    localparam int DRW   = plvr_pkg::DREM_W;

    // ------------------------------------------------------------------
    // configuration registers: user writes only while the pipe is empty, not enforced
    // ------------------------------------------------------------------
    logic [RGW-1:0] const_reg;
    logic [RGW-1:0] lin_reg;
    logic [RGW-1:0] quad_reg;
    logic [RGW-1:0] gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            const_reg <= plvr_pkg::CONST_RST;
            lin_reg   <= plvr_pkg::LIN_RST;
            quad_reg  <= plvr_pkg::QUAD_RST;
            gain_reg  <= plvr_pkg::GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (plvr_pkg::reg_idx_t'(cfg_index))
                plvr_pkg::REG_CONST: const_reg <= cfg_data;
                plvr_pkg::REG_LIN:   lin_reg   <= cfg_data;
                plvr_pkg::REG_QUAD:  quad_reg  <= cfg_data;
                plvr_pkg::REG_GAIN:  gain_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline advance: every stage moves together unless the result is held
    // ------------------------------------------------------------------
    logic en;
    plvr_pkg::tag_t out_tag_reg;

    assign en       = !out_tag_reg.valid || out_ready;
    assign in_ready = en;

    // stage 1: brightest channel, quadratic-zero check
    plvr_pkg::tag_t  tag1_reg, tag1_next;
    logic [CW-1:0]   m_reg, m_next;
    logic [CW-1:0]   rg_max;

    always_comb
    begin
        rg_max          = (color_red > color_green) ? color_red : color_green;
        m_next          = (color_blue > rg_max) ? color_blue : rg_max;
        tag1_next.valid   = in_valid;
        tag1_next.status  = (quad_reg == '0) ? plvr_pkg::ST_QZERO : plvr_pkg::ST_OK;
        tag1_next.sat_max = 1'b0;
    end

    // stage 2: t = floor((m << (F-7)) / 5) through a reciprocal multiply
    plvr_pkg::tag_t  tag2_reg;
    logic [TW-1:0]   t_reg;
    logic [XW-1:0]   x_val;
    logic [XPW-1:0]  x_prod;

    assign x_val  = XW'(m_reg) << (FRAC_BITS - 7);
    assign x_prod = XPW'(x_val) * XPW'(plvr_pkg::RECIP5);

    // stage 3: the three products of the discriminant
    plvr_pkg::tag_t  tag3_reg;
    logic [2*RGW-1:0] lin2_reg;
    logic [QTW-1:0]   qt_reg;
    logic [NGW-1:0]   ng_reg;

    // stage 4: discriminant and its sign
    plvr_pkg::tag_t  tag4_reg, tag4_next;
    logic [DW-1:0]   d_reg;
    logic [DW-1:0]   pos_val;
    logic [DW-1:0]   neg_val;

    assign pos_val = DW'(lin2_reg) + DW'(qt_reg);
    assign neg_val = DW'(ng_reg);

    always_comb
    begin
        tag4_next = tag3_reg;
        if (tag3_reg.status == plvr_pkg::ST_OK && pos_val < neg_val)
        begin
            tag4_next.status = plvr_pkg::ST_NEGDISC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
        end
        else if (en)
        begin
            tag1_reg <= tag1_next;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg    <= m_next;
            t_reg    <= x_prod[plvr_pkg::RECIP_SHIFT +: TW];
            lin2_reg <= (2*RGW)'(lin_reg) * (2*RGW)'(lin_reg);
            qt_reg   <= QTW'(quad_reg) * QTW'({t_reg, 2'b00});
            ng_reg   <= NGW'({quad_reg, 2'b00}) * NGW'(const_reg);
            d_reg    <= pos_val - neg_val;
        end
    end

    // ------------------------------------------------------------------
    // square root, one bit per stage
    // ------------------------------------------------------------------
    plvr_pkg::tag_t  sq_tag;
    logic [SRW-1:0]  sq_root;

    plvr_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_tag   (tag4_reg),
        .in_d     (d_reg),
        .out_tag  (sq_tag),
        .out_root (sq_root)
    );

    // stage 5: numerator, negative radius check
    plvr_pkg::tag_t  tag5_reg, tag5_next;
    logic [SRW-1:0]  num_reg;
    logic [SRW-1:0]  lin_ext;

    assign lin_ext = SRW'(lin_reg);

    always_comb
    begin
        tag5_next = sq_tag;
        if (sq_tag.status == plvr_pkg::ST_OK && sq_root < lin_ext)
        begin
            tag5_next.status = plvr_pkg::ST_SAT;
        end
    end

    // stage 6: numerator times gain
    plvr_pkg::tag_t  tag6_reg;
    logic [PW-1:0]   prod_reg;

    // stage 7: overflow check, quotient of 2^32 or more saturates
    plvr_pkg::tag_t        tag7_reg, tag7_next;
    logic [DRW-1:0]        drem_reg;
    logic [RGW-1:0]        dlo_reg;
    logic [plvr_pkg::DV_W-1:0] dv_val;

    assign dv_val = {quad_reg, 1'b0};

    always_comb
    begin
        tag7_next = tag6_reg;
        if (tag6_reg.status == plvr_pkg::ST_OK && prod_reg[PW-1:RGW] >= DRW'(dv_val))
        begin
            tag7_next.status  = plvr_pkg::ST_SAT;
            tag7_next.sat_max = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag5_reg <= '0;
            tag6_reg <= '0;
            tag7_reg <= '0;
        end
        else if (en)
        begin
            tag5_reg <= tag5_next;
            tag6_reg <= tag5_reg;
            tag7_reg <= tag7_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= sq_root - lin_ext;
            prod_reg <= PW'(num_reg) * PW'(gain_reg);
            drem_reg <= prod_reg[PW-1:RGW];
            dlo_reg  <= prod_reg[RGW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // divide by twice the quadratic term, one quotient bit per stage
    // ------------------------------------------------------------------
    plvr_pkg::tag_t  dv_tag;
    logic [RGW-1:0]  dv_q;

    plvr_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_tag  (tag7_reg),
        .in_rem  (drem_reg),
        .in_lo   (dlo_reg),
        .dv      (dv_val),
        .out_tag (dv_tag),
        .out_q   (dv_q)
    );

    // ------------------------------------------------------------------
    // output register: special cases force the radius
    // ------------------------------------------------------------------
    logic [RGW-1:0] radius_reg, radius_next;

    always_comb
    begin
        if (dv_tag.status == plvr_pkg::ST_OK)
        begin
            radius_next = dv_q;
        end
        else if (dv_tag.sat_max)
        begin
            radius_next = '1;
        end
        else
        begin
            radius_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_tag_reg <= '0;
        end
        else if (en)
        begin
            out_tag_reg <= dv_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            radius_reg <= radius_next;
        end
    end

    assign out_valid    = out_tag_reg.valid;
    assign status       = out_tag_reg.status;
    assign light_radius = radius_reg;

`ifndef SYNTHESIS
    // quadratic zero and negative discriminant always give a zero radius
    a_special_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == plvr_pkg::ST_QZERO || status == plvr_pkg::ST_NEGDISC)
        |-> light_radius == '0)
        else $error("special case result not zero");

    // a saturated result is only ever zero or all ones
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == plvr_pkg::ST_SAT
        |-> (light_radius == '0 || light_radius == '1))
        else $error("saturated result out of range");

    // a held result keeps the input side stalled
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result held");
`endif

endmodule

// ===== tb/plvr_checker.sv =====
`timescale 1ns / 1ps

module plvr_checker
    import plvr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [COLOR_W-1:0]  color_red,
    input  logic [COLOR_W-1:0]  color_green,
    input  logic [COLOR_W-1:0]  color_blue,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [REG_W-1:0]    light_radius,
    input  logic [1:0]          status,
    input  logic                cfg_we,
    input  logic [CFG_IW-1:0]   cfg_index,
    input  logic [REG_W-1:0]    cfg_data,
    output int                  pending,
    output int                  fail_count
);

    localparam int FB = FRAC_BITS_DEF;

    typedef struct {
        logic [REG_W-1:0] radius;
        status_t          st;
    } light_result_t;

    light_result_t radius_q[$];

    logic [REG_W-1:0] att_const = CONST_RST;
    logic [REG_W-1:0] att_lin   = LIN_RST;
    logic [REG_W-1:0] att_quad  = QUAD_RST;
    logic [REG_W-1:0] gain      = GAIN_RST;

    int fail_cnt = 0;

    // radius from the brightest channel, exact wide arithmetic
    function automatic light_result_t light_radius_of(logic [15:0] r, logic [15:0] g,
                                                      logic [15:0] b);
        logic [15:0]   m;
        logic [63:0]   t;
        logic [63:0]   root;
        logic [63:0]   cand;
        logic [127:0]  pos;
        logic [127:0]  neg;
        logic [127:0]  disc;
        logic [127:0]  quo;
        light_result_t res;
        m = (r > g) ? r : g;
        if (b > m) m = b;
        res.radius = '0;
        res.st = ST_OK;
        if (att_quad == 0)
        begin
            res.st = ST_QZERO;
            return res;
        end
        t = ({48'd0, m} << (FB + 8)) / (64'd5 << 15);
        pos = 128'(att_lin) * 128'(att_lin) + 128'(att_quad) * 128'(t << 2);
        neg = (128'(att_quad) << 2) * 128'(att_const);
        if (pos < neg)
        begin
            res.st = ST_NEGDISC;
            return res;
        end
        disc = pos - neg;
        root = 0;
        for (int k = 35; k >= 0; k--)
        begin
            cand = root | (64'd1 << k);
            if (128'(cand) * 128'(cand) <= disc) root = cand;
        end
        if (root < 64'(att_lin))
        begin
            res.st = ST_SAT;
            return res;
        end
        quo = (128'(root - 64'(att_lin)) * 128'(gain)) / (128'(att_quad) << 1);
        if (quo > 128'hFFFF_FFFF)
        begin
            res.radius = '1;
            res.st = ST_SAT;
        end
        else
        begin
            res.radius = quo[31:0];
        end
        return res;
    endfunction

    assign fail_count = fail_cnt;

    always @(posedge clk)
    begin
        light_result_t exp_res;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_CONST: att_const <= cfg_data;
                    REG_LIN:   att_lin   <= cfg_data;
                    REG_QUAD:  att_quad  <= cfg_data;
                    REG_GAIN:  gain      <= cfg_data;
                    default:   ;
                endcase
            end
            if (in_valid && in_ready)
                radius_q.push_back(light_radius_of(color_red, color_green, color_blue));
            if (out_valid && out_ready)
            begin
                if (radius_q.size() == 0)
                begin
                    $error("result with no item pending: radius %h status %0d",
                           light_radius, status);
                    fail_cnt++;
                end
                else
                begin
                    exp_res = radius_q.pop_front();
                    if (light_radius !== exp_res.radius)
                    begin
                        $error("light_radius expected %h actual %h",
                               exp_res.radius, light_radius);
                        fail_cnt++;
                    end
                    if (status !== exp_res.st)
                    begin
                        $error("status expected %0d actual %0d", exp_res.st, status);
                        fail_cnt++;
                    end
                end
            end
        end
        pending = radius_q.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import plvr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 100;   // comfortably past the pipe depth

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [COLOR_W-1:0]  color_red = '0;
    logic [COLOR_W-1:0]  color_green = '0;
    logic [COLOR_W-1:0]  color_blue = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [REG_W-1:0]    light_radius;
    logic [1:0]          status;
    logic                cfg_we = 1'b0;
    logic [CFG_IW-1:0]   cfg_index = '0;
    logic [REG_W-1:0]    cfg_data = '0;

    int pending;
    int fail_count;
    int cycle_cnt = 0;
    int hold_cnt = 0;
    logic no_idle;

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    point_light_volume_radius_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .color_red(color_red), .color_green(color_green), .color_blue(color_blue),
        .out_valid(out_valid), .out_ready(out_ready),
        .light_radius(light_radius), .status(status),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    plvr_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .color_red(color_red), .color_green(color_green), .color_blue(color_blue),
        .out_valid(out_valid), .out_ready(out_ready),
        .light_radius(light_radius), .status(status),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pending(pending), .fail_count(fail_count)
    );

    // a window where neither side idles
    assign no_idle = (cycle_cnt >= 800) && (cycle_cnt < 1600);

    // timeout watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off so the pipe fills
    // and in_ready has to drop
    always @(posedge clk)
    begin
        if (cycle_cnt == 2500)
            hold_cnt <= 400;
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;

        if (!rst_n || hold_cnt > 0 || cycle_cnt == 2500)
            out_ready <= 1'b0;
        else if (no_idle)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= 35);
    end

    // offer one item and wait for it to be taken; valid then stays up
    // unless a random gap follows; in_ready only moves at the rising edge,
    // so the falling edge shows the value the next rising edge will use
    task automatic send_light(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        in_valid    <= 1'b1;
        color_red   <= r;
        color_green <= g;
        color_blue  <= b;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        // random gap before the next item
        if (!no_idle && $urandom_range(0, 99) < 35)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // wait for the pipe to drain before touching the registers
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // one write per cycle, enable dropped once after the last
    task automatic load_atten(logic [31:0] c, logic [31:0] l, logic [31:0] q,
                              logic [31:0] g);
        cfg_we <= 1'b1;
        cfg_index <= REG_CONST; cfg_data <= c; @(posedge clk);
        cfg_index <= REG_LIN;   cfg_data <= l; @(posedge clk);
        cfg_index <= REG_QUAD;  cfg_data <= q; @(posedge clk);
        cfg_index <= REG_GAIN;  cfg_data <= g; @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // mostly legal Q1.15 colors, some raw values above 1.0
    function automatic logic [15:0] rand_color();
        if ($urandom_range(0, 99) < 70)
            return 16'($urandom_range(0, 32768));
        return 16'($urandom);
    endfunction

    task automatic send_random(int n);
        repeat (n)
            send_light(rand_color(), rand_color(), rand_color());
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: channel extremes, each channel brightest in turn
        send_light(16'd0, 16'd0, 16'd0);
        send_light(16'd32768, 16'd32768, 16'd32768);
        send_light(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_light(16'd32768, 16'd0, 16'd0);
        send_light(16'd0, 16'd32768, 16'd0);
        send_light(16'd0, 16'd0, 16'd32768);
        send_light(16'hAAAA, 16'h5555, 16'h0001);
        send_light(16'h5555, 16'hAAAA, 16'hFFFE);
        send_light(16'd1, 16'd2, 16'd3);
        send_light(16'd205, 16'd0, 16'd0);
        send_random(200);

        // large linear term: dim lights give a root below it, clamped to zero
        wait_idle();
        load_atten(32'd65536, 32'd655360, 32'd65536, 32'd65536);
        send_light(16'd0, 16'd0, 16'd0);
        send_light(16'd100, 16'd0, 16'd0);
        send_light(16'd32768, 16'd32768, 16'd32768);
        send_random(150);

        // zero quadratic term
        wait_idle();
        load_atten(32'd65536, 32'd45875, 32'd0, 32'd65536);
        send_light(16'd32768, 16'd0, 16'd0);
        send_light(16'd0, 16'd0, 16'd0);
        send_random(60);

        // every register at its maximum
        wait_idle();
        load_atten(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_light(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_random(100);

        // tiny quadratic and full gain: bright lights saturate the radius
        wait_idle();
        load_atten(32'd0, 32'd0, 32'd1, 32'hFFFF_FFFF);
        send_light(16'hFFFF, 16'd0, 16'd0);
        send_light(16'd0, 16'd0, 16'd0);
        send_random(100);

        // zero constant, linear and gain
        wait_idle();
        load_atten(32'd0, 32'd0, 32'd65536, 32'd0);
        send_random(100);

        // moderate random settings
        repeat (6)
        begin
            wait_idle();
            load_atten($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20),
                       $urandom_range(1, 1 << 20), $urandom_range(0, 1 << 19));
            send_random(215);
        end

        wait_idle();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/plvr_pkg.sv
hdl/plvr_sqrt.sv
hdl/plvr_div.sv
hdl/point_light_volume_radius_top.sv
tb/plvr_checker.sv
tb/tb.sv
